[rtl/cpe_pkg.sv]
// ----------------------------------------------------------------------------
// Cart-pole step package
// Shared types, fixed-point constants, the arctangent table and the saturation
// helpers of the cart-pole Euler step block.
// ----------------------------------------------------------------------------
package cpe_pkg;

    typedef enum logic [2:0] {
        S_IDLE,
        S_MOD,
        S_CORDIC,
        S_MUL,
        S_DIV,
        S_DONE
    } state_t;

    // Configuration register indexes.
    localparam logic [1:0] REG_TIME_STEP      = 2'd0;
    localparam logic [1:0] REG_POSITION_LIMIT = 2'd1;
    localparam logic [1:0] REG_ANGLE_LIMIT    = 2'd2;

    // Operation codes carried in the input tuser.
    localparam logic OP_LOAD = 1'b0;
    localparam logic OP_STEP = 1'b1;

    // Q24 constants held at the intermediate width.
    localparam logic signed [38:0] C_ONE          = 39'sd16777216;
    localparam logic signed [38:0] C_FOUR_THIRDS  = 39'sd22369621;
    localparam logic signed [38:0] C_GRAVITY      = 39'sd164416717;
    localparam logic signed [38:0] C_MASSPOLE     = 39'sd1677722;
    localparam logic signed [38:0] C_INV_TOTAL    = 39'sd15252015;
    localparam logic signed [38:0] C_HALF_LEN     = 39'sd8388608;
    localparam logic signed [38:0] C_POLEMASS_LEN = 39'sd838861;
    localparam logic signed [38:0] INNER_MAX      = 39'sh3F_FFFF_FFFF;
    localparam logic signed [38:0] INNER_MIN      = 39'sh40_0000_0000;

    localparam logic signed [28:0] C_PI      = 29'sd52707179;
    localparam logic signed [28:0] C_TWO_PI  = 29'sd105414358;
    localparam logic signed [28:0] C_HALF_PI = 29'sd26353590;
    localparam logic signed [33:0] CORDIC_GAIN = 34'sd652032874;

    // Micro-program step indexes that need special handling.
    localparam logic [4:0] ST_LAST = 5'd16;
    localparam logic [4:0] ST_DEN  = 5'd9;

    // arctan(2^-i) in Q30.
    function automatic logic [29:0] atan_q30(input logic [4:0] idx);
        logic [29:0] r;
        begin
            case (idx)
                5'd0:  r = 30'd843314857;
                5'd1:  r = 30'd497837829;
                5'd2:  r = 30'd263043836;
                5'd3:  r = 30'd133525158;
                5'd4:  r = 30'd67021686;
                5'd5:  r = 30'd33543515;
                5'd6:  r = 30'd16775850;
                5'd7:  r = 30'd8388437;
                5'd8:  r = 30'd4194282;
                5'd9:  r = 30'd2097149;
                5'd10: r = 30'd1048575;
                5'd11: r = 30'd524287;
                5'd12: r = 30'd262143;
                5'd13: r = 30'd131071;
                5'd14: r = 30'd65535;
                5'd15: r = 30'd32767;
                5'd16: r = 30'd16383;
                5'd17: r = 30'd8191;
                5'd18: r = 30'd4095;
                5'd19: r = 30'd2047;
                5'd20: r = 30'd1023;
                5'd21: r = 30'd511;
                5'd22: r = 30'd255;
                5'd23: r = 30'd127;
                5'd24: r = 30'd63;
                5'd25: r = 30'd31;
                5'd26: r = 30'd15;
                5'd27: r = 30'd8;
                5'd28: r = 30'd4;
                5'd29: r = 30'd2;
                5'd30: r = 30'd1;
                default: r = 30'd0;
            endcase
            return r;
        end
    endfunction

    // True when a 41-bit value lies outside the 39-bit intermediate range.
    function automatic logic out39(input logic signed [40:0] v);
        return (v > 41'(INNER_MAX)) || (v < 41'(INNER_MIN));
    endfunction

    function automatic logic signed [38:0] clip39(input logic signed [40:0] v);
        logic signed [38:0] r;
        begin
            if (v > 41'(INNER_MAX)) r = INNER_MAX;
            else if (v < 41'(INNER_MIN)) r = INNER_MIN;
            else r = v[38:0];
            return r;
        end
    endfunction

    function automatic logic out32(input logic signed [40:0] v);
        return (v > 41'sd2147483647) || (v < -41'sd2147483648);
    endfunction

    function automatic logic signed [31:0] clip32(input logic signed [40:0] v);
        logic signed [31:0] r;
        begin
            if (v > 41'sd2147483647) r = 32'sh7FFF_FFFF;
            else if (v < -41'sd2147483648) r = 32'sh8000_0000;
            else r = v[31:0];
            return r;
        end
    endfunction

endpackage

[rtl/cart_pole_euler_step.sv]
// ----------------------------------------------------------------------------
// Cart-pole Euler step
// Holds the cart-pole state in Q8.24 and advances it one explicit Euler step
// per step word, or loads it from a load word, using one shared multiplier.
// ----------------------------------------------------------------------------
// Sequencing: a load word passes through S_DONE before its result shows; a step
// word runs S_MOD, S_CORDIC, S_MUL, S_DIV, S_MUL and S_DONE in turn, with at most
// 20 subtractions of 2*pi in the angle reduction of S_MOD.
// Throughput: one word at a time; s_tready rises as the result is
// loaded, and a result still held on the output stalls the block in its last state.
// Reset: aresetn is synchronous, active low; the state clears to zero and the
// configuration registers take their defaults.
module cart_pole_euler_step #(
    parameter int TRIG_ITERATIONS = 24
) (
    input  logic         aclk,
    input  logic         aresetn,
    // Configuration write port.
    input  logic         cfg_wr_en,
    input  logic [1:0]   cfg_wr_addr,
    input  logic [30:0]  cfg_wr_data,
    // Input stream.
    input  logic         s_tvalid,
    output logic         s_tready,
    // force_req, load_position, load_velocity, load_angle, load_angular_rate
    input  logic [159:0] s_tdata,
    // op
    input  logic [0:0]   s_tuser,
    // Result stream.
    output logic         m_tvalid,
    input  logic         m_tready,
    // position, velocity, angle, angular_rate
    output logic [127:0] m_tdata,
    // terminal, reward, saturated
    output logic [2:0]   m_tuser
);
    import cpe_pkg::*;

    // The CORDIC never runs more than the 32 indexes of the 5-bit table.
    localparam int NITER = (TRIG_ITERATIONS < 32) ? TRIG_ITERATIONS : 32;
    localparam int DIV_STEPS = 63;

    state_t state_reg, state_next;

    // Configuration.
    logic [23:0] dt_reg;
    logic [30:0] plim_reg, alim_reg;

    // Architectural state.
    logic signed [31:0] pos_reg, vel_reg, ang_reg, rate_reg;
    logic signed [31:0] force_reg;

    // Intermediates of a step.
    logic signed [38:0] sn_reg, cs_reg, t_reg, temp_reg, num_reg, den_reg;
    logic signed [38:0] tacc_reg, xacc_reg, mres_reg;
    logic               sat_reg;

    // Angle reduction and CORDIC.
    logic [31:0]        mag_reg;
    logic               neg_reg, flip_reg;
    logic signed [33:0] x_reg, y_reg, z_reg;
    logic [5:0]         iter_reg;

    // Divider.
    logic [39:0]        rem_reg;
    logic [62:0]        dq_reg;

    // Multiplier sequencing: step of the micro-program and phase within it.
    logic [4:0]         step_reg;
    logic [1:0]         phase_reg;
    logic signed [77:0] acc_reg;

    // Result register.
    logic               m_valid_reg;
    logic [127:0]       m_data_reg;
    logic [2:0]         m_user_reg;

    logic in_fire, out_free;
    assign in_fire  = s_tvalid && s_tready;
    assign out_free = !m_valid_reg || m_tready;

    // ------------------------------------------------------------------
    // Operand selection for the shared multiplier.
    // ------------------------------------------------------------------
    logic signed [38:0] op_a, op_b;
    logic signed [38:0] dt_op;
    assign dt_op = $signed({15'd0, dt_reg});

    always_comb begin
        op_a = t_reg;
        op_b = C_INV_TOTAL;
        case (step_reg)
            5'd0:  begin op_a = 39'(rate_reg); op_b = 39'(rate_reg); end
            5'd1:  begin op_a = t_reg;         op_b = sn_reg;         end
            5'd2:  begin op_a = t_reg;         op_b = C_POLEMASS_LEN; end
            5'd3:  begin op_a = t_reg;         op_b = C_INV_TOTAL;    end
            5'd4:  begin op_a = sn_reg;        op_b = C_GRAVITY;      end
            5'd5:  begin op_a = temp_reg;      op_b = cs_reg;         end
            5'd6:  begin op_a = cs_reg;        op_b = cs_reg;         end
            5'd7:  begin op_a = t_reg;         op_b = C_MASSPOLE;     end
            5'd8:  begin op_a = t_reg;         op_b = C_INV_TOTAL;    end
            5'd9:  begin op_a = C_HALF_LEN;    op_b = t_reg;          end
            5'd10: begin op_a = tacc_reg;      op_b = C_POLEMASS_LEN; end
            5'd11: begin op_a = t_reg;         op_b = cs_reg;         end
            5'd12: begin op_a = t_reg;         op_b = C_INV_TOTAL;    end
            5'd13: begin op_a = 39'(vel_reg);  op_b = dt_op;          end
            5'd14: begin op_a = xacc_reg;      op_b = dt_op;          end
            5'd15: begin op_a = 39'(rate_reg); op_b = dt_op;          end
            5'd16: begin op_a = tacc_reg;      op_b = dt_op;          end
            default: begin op_a = t_reg;       op_b = C_INV_TOTAL;    end
        endcase
    end

    // Two partial products: low 20 bits of b, then its signed upper part.
    logic signed [59:0] pp_lo;
    logic signed [57:0] pp_hi;
    logic signed [77:0] acc_rnd;
    logic signed [53:0] prod_q24;
    assign pp_lo    = op_a * $signed({1'b0, op_b[19:0]});
    assign pp_hi    = op_a * $signed(op_b[38:20]);
    assign acc_rnd  = acc_reg + 78'sd8388608;
    assign prod_q24 = acc_rnd[77:24];

    // Writeback adders, fed by the registered rounded product.
    logic signed [40:0] wb_sum;
    always_comb begin
        case (step_reg)
            5'd2:    wb_sum = 41'(force_reg) + 41'(mres_reg);
            5'd5:    wb_sum = 41'(num_reg) - 41'(mres_reg);
            5'd8:    wb_sum = 41'(C_FOUR_THIRDS) - 41'(mres_reg);
            5'd12:   wb_sum = 41'(temp_reg) - 41'(mres_reg);
            5'd13:   wb_sum = 41'(pos_reg) + 41'(mres_reg);
            5'd14:   wb_sum = 41'(vel_reg) + 41'(mres_reg);
            5'd15:   wb_sum = 41'(ang_reg) + 41'(mres_reg);
            5'd16:   wb_sum = 41'(rate_reg) + 41'(mres_reg);
            default: wb_sum = 41'(mres_reg);
        endcase
    end

    // ------------------------------------------------------------------
    // Angle reduction to [-pi/2, pi/2] once the magnitude is below 2*pi.
    // ------------------------------------------------------------------
    logic signed [28:0] r0, r1, r2;
    logic               fold;
    always_comb begin
        r0 = neg_reg ? -$signed({1'b0, mag_reg[27:0]}) : $signed({1'b0, mag_reg[27:0]});
        r1 = r0;
        if (r0 > C_PI) r1 = r0 - C_TWO_PI;
        else if (r0 < -C_PI) r1 = r0 + C_TWO_PI;
        fold = 1'b0;
        r2 = r1;
        if (r1 > C_HALF_PI) begin
            r2 = r1 - C_PI;
            fold = 1'b1;
        end else if (r1 < -C_HALF_PI) begin
            r2 = r1 + C_PI;
            fold = 1'b1;
        end
    end

    logic mod_busy;
    assign mod_busy = (mag_reg >= 32'(C_TWO_PI));

    // ------------------------------------------------------------------
    // CORDIC rotation step and output rounding.
    // ------------------------------------------------------------------
    logic signed [33:0] x_sh, y_sh, atan_v;
    assign x_sh   = x_reg >>> iter_reg[4:0];
    assign y_sh   = y_reg >>> iter_reg[4:0];
    assign atan_v = $signed({4'd0, atan_q30(iter_reg[4:0])});

    logic signed [33:0] x_rnd, y_rnd;
    logic signed [27:0] x_q24, y_q24, x_cl, y_cl;
    assign x_rnd = (x_reg + 34'sd32) >>> 6;
    assign y_rnd = (y_reg + 34'sd32) >>> 6;
    always_comb begin
        x_q24 = x_rnd[27:0];
        y_q24 = y_rnd[27:0];
        if (x_q24 > 28'sd16777216) x_cl = 28'sd16777216;
        else if (x_q24 < -28'sd16777216) x_cl = -28'sd16777216;
        else x_cl = x_q24;
        if (y_q24 > 28'sd16777216) y_cl = 28'sd16777216;
        else if (y_q24 < -28'sd16777216) y_cl = -28'sd16777216;
        else y_cl = y_q24;
    end

    // ------------------------------------------------------------------
    // Restoring divider step: one quotient bit per cycle.
    // ------------------------------------------------------------------
    logic [40:0] div_diff;
    assign div_diff = {1'b0, rem_reg[38:0], dq_reg[62]} - {2'b00, den_reg[38:0]};

    logic [38:0] num_mag;
    assign num_mag = num_reg[38] ? 39'(-num_reg) : num_reg;

    // Quotient sign and clip to the intermediate range.
    logic signed [38:0] q_clip;
    logic               q_sat;
    always_comb begin
        if (!num_reg[38]) begin
            q_sat  = (dq_reg > 63'(INNER_MAX));
            q_clip = q_sat ? INNER_MAX : $signed(dq_reg[38:0]);
        end else begin
            q_sat  = (dq_reg > 63'h40_0000_0000);
            q_clip = q_sat ? INNER_MIN : $signed(39'(-dq_reg[38:0]));
        end
    end

    // Terminal check on the current state.
    logic term;
    assign term = (33'(pos_reg) < -$signed({2'b00, plim_reg}))
               || (33'(pos_reg) >  $signed({2'b00, plim_reg}))
               || (33'(ang_reg) < -$signed({2'b00, alim_reg}))
               || (33'(ang_reg) >  $signed({2'b00, alim_reg}));

    // ------------------------------------------------------------------
    // Sequencer: next state.
    // ------------------------------------------------------------------
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE: begin
                if (in_fire) state_next = (s_tuser[0] == OP_STEP) ? S_MOD : S_DONE;
            end
            S_MOD: begin
                if (!mod_busy) state_next = S_CORDIC;
            end
            S_CORDIC: begin
                if (iter_reg == 6'(NITER)) state_next = S_MUL;
            end
            S_MUL: begin
                if (phase_reg == 2'd3) begin
                    if (step_reg == ST_DEN) state_next = S_DIV;
                    else if (step_reg == ST_LAST) state_next = S_DONE;
                end
            end
            S_DIV: begin
                if (iter_reg == 6'(DIV_STEPS)) state_next = S_MUL;
            end
            S_DONE: begin
                if (out_free) state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

    // Sequencer: outputs.
    always_comb begin
        s_tready = (state_reg == S_IDLE);
        m_tvalid = m_valid_reg;
        m_tdata  = m_data_reg;
        m_tuser  = m_user_reg;
    end

    // ------------------------------------------------------------------
    // Control registers.
    // ------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            m_valid_reg <= 1'b0;
            dt_reg      <= 24'd335544;
            plim_reg    <= 31'd40265318;
            alim_reg    <= 31'd3513793;
            pos_reg     <= '0;
            vel_reg     <= '0;
            ang_reg     <= '0;
            rate_reg    <= '0;
        end else begin
            state_reg <= state_next;
            if (cfg_wr_en) begin
                case (cfg_wr_addr)
                    REG_TIME_STEP:      dt_reg   <= cfg_wr_data[23:0];
                    REG_POSITION_LIMIT: plim_reg <= cfg_wr_data;
                    REG_ANGLE_LIMIT:    alim_reg <= cfg_wr_data;
                    default: ;
                endcase
            end
            if (state_reg == S_DONE && out_free) m_valid_reg <= 1'b1;
            else if (m_valid_reg && m_tready) m_valid_reg <= 1'b0;

            // State updates: load, or the four Euler writebacks.
            if (state_reg == S_IDLE && in_fire && s_tuser[0] == OP_LOAD) begin
                pos_reg  <= s_tdata[63:32];
                vel_reg  <= s_tdata[95:64];
                ang_reg  <= s_tdata[127:96];
                rate_reg <= s_tdata[159:128];
            end
            if (state_reg == S_MUL && phase_reg == 2'd3) begin
                case (step_reg)
                    5'd13:   pos_reg  <= clip32(wb_sum);
                    5'd14:   vel_reg  <= clip32(wb_sum);
                    5'd15:   ang_reg  <= clip32(wb_sum);
                    5'd16:   rate_reg <= clip32(wb_sum);
                    default: ;
                endcase
            end
        end
    end

    // ------------------------------------------------------------------
    // Datapath registers.
    // ------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        case (state_reg)
            S_IDLE: begin
                force_reg <= s_tdata[31:0];
                neg_reg   <= ang_reg[31];
                sat_reg   <= 1'b0;
                step_reg  <= '0;
                phase_reg <= '0;
                iter_reg  <= '0;
                // The angle magnitude is taken from the held state.
                mag_reg   <= ang_reg[31] ? 32'(-ang_reg) : 32'(ang_reg);
            end
            S_MOD: begin
                if (mod_busy) begin
                    mag_reg <= mag_reg - 32'(C_TWO_PI);
                end else begin
                    x_reg    <= CORDIC_GAIN;
                    y_reg    <= '0;
                    z_reg    <= 34'(r2) <<< 6;
                    flip_reg <= fold;
                    iter_reg <= '0;
                end
            end
            S_CORDIC: begin
                if (iter_reg != 6'(NITER)) begin
                    if (!z_reg[33]) begin
                        x_reg <= x_reg - y_sh;
                        y_reg <= y_reg + x_sh;
                        z_reg <= z_reg - atan_v;
                    end else begin
                        x_reg <= x_reg + y_sh;
                        y_reg <= y_reg - x_sh;
                        z_reg <= z_reg + atan_v;
                    end
                    iter_reg <= iter_reg + 6'd1;
                end else begin
                    cs_reg <= flip_reg ? 39'(-x_cl) : 39'(x_cl);
                    sn_reg <= flip_reg ? 39'(-y_cl) : 39'(y_cl);
                end
            end
            S_MUL: begin
                phase_reg <= phase_reg + 2'd1;
                case (phase_reg)
                    2'd0: acc_reg <= 78'(pp_lo);
                    2'd1: acc_reg <= acc_reg + (78'(pp_hi) <<< 20);
                    2'd2: begin
                        mres_reg <= clip39(41'(prod_q24));
                        if ((prod_q24 > 54'(INNER_MAX)) || (prod_q24 < 54'(INNER_MIN)))
                            sat_reg <= 1'b1;
                    end
                    default: begin
                        step_reg <= step_reg + 5'd1;
                        case (step_reg)
                            5'd2, 5'd12: begin
                                if (step_reg == 5'd2) t_reg <= clip39(wb_sum);
                                else xacc_reg <= clip39(wb_sum);
                                if (out39(wb_sum)) sat_reg <= 1'b1;
                            end
                            5'd3:  temp_reg <= mres_reg;
                            5'd4:  num_reg  <= mres_reg;
                            5'd5: begin
                                num_reg <= clip39(wb_sum);
                                if (out39(wb_sum)) sat_reg <= 1'b1;
                            end
                            5'd8:  t_reg <= wb_sum[38:0];
                            5'd9: begin
                                den_reg  <= (mres_reg < 39'sd1) ? 39'sd1 : mres_reg;
                                rem_reg  <= '0;
                                dq_reg   <= {num_mag, 24'd0};
                                iter_reg <= '0;
                            end
                            5'd13, 5'd14, 5'd15, 5'd16: begin
                                if (out32(wb_sum)) sat_reg <= 1'b1;
                            end
                            default: t_reg <= mres_reg;
                        endcase
                    end
                endcase
            end
            S_DIV: begin
                if (iter_reg != 6'(DIV_STEPS)) begin
                    if (!div_diff[40]) begin
                        rem_reg <= div_diff[39:0];
                        dq_reg  <= {dq_reg[61:0], 1'b1};
                    end else begin
                        rem_reg <= {rem_reg[38:0], dq_reg[62]};
                        dq_reg  <= {dq_reg[61:0], 1'b0};
                    end
                    iter_reg <= iter_reg + 6'd1;
                end else begin
                    tacc_reg <= q_clip;
                    if (q_sat) sat_reg <= 1'b1;
                end
            end
            S_DONE: begin
                if (out_free) begin
                    m_data_reg <= {rate_reg, ang_reg, vel_reg, pos_reg};
                    m_user_reg <= {sat_reg, term, term};
                end
            end
            default: ;
        endcase
    end

endmodule
